FILE: design/usnd_pkg.sv
// ----------------------------------------------------------------------------
// usnd_pkg
// Shared types and constants for the USB sync detect and NRZI line decoder.
// ----------------------------------------------------------------------------
package usnd_pkg;

   // field widths
   localparam int INDEX_W    = 16;
   localparam int PATTERN_W  = 16;
   localparam int CSR_ADDR_W = 8;
   localparam int CSR_DATA_W = 16;

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_SYNC_PATTERN  = 8'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_DEBUG_CAPTURE = 8'd1;

   // register reset values
   localparam logic [PATTERN_W-1:0] SYNC_PATTERN_RESET = 16'd22937;

   // decoder phase
   typedef enum logic [1:0] {
      PHASE_WAIT    = 2'd0,
      PHASE_SYNC    = 2'd1,
      PHASE_ANALYZE = 2'd2,
      PHASE_CAPTURE = 2'd3
   } phase_type;

   // classified line symbol
   typedef struct packed {
      logic dplus;
      logic dminus;
      logic se0;
   } sym_type;

   // queue head as seen by the back end
   typedef struct packed {
      logic    valid;
      sym_type sym;
   } head_type;

endpackage

FILE: design/usnd_if.sv
// ----------------------------------------------------------------------------
// usnd_if
// Handshake channels: line symbol beats, decoder result beats, register writes.
// ----------------------------------------------------------------------------
interface usnd_req_if;
   logic valid;
   logic ready;
   logic dplus;
   logic dminus;

   modport source (output valid, output dplus, output dminus, input ready);
   modport sink   (input valid, input dplus, input dminus, output ready);
endinterface

interface usnd_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  phase;
   logic        bit_valid;
   logic        bit_value;
   logic [15:0] bit_index;
   logic        raw_valid;
   logic        raw_dplus;
   logic        raw_dminus;
   logic        sync_detected;
   logic        end_of_packet;
   logic        overflow;
   logic        stopped;

   modport source (output valid, output phase, output bit_valid, output bit_value,
                   output bit_index, output raw_valid, output raw_dplus,
                   output raw_dminus, output sync_detected, output end_of_packet,
                   output overflow, output stopped, input ready);
   modport sink   (input valid, input phase, input bit_valid, input bit_value,
                   input bit_index, input raw_valid, input raw_dplus,
                   input raw_dminus, input sync_detected, input end_of_packet,
                   input overflow, input stopped, output ready);
endinterface

interface usnd_csr_if;
   logic        valid;
   logic        ready;
   logic [7:0]  index;
   logic [15:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: design/usnd_front.sv
// ----------------------------------------------------------------------------
// usnd_front
// Accepts line symbol beats, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module usnd_front
   import usnd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   usnd_req_if.sink   req_bus,
   output head_type   head,
   input  logic       pop
);

   sym_type    mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   logic       do_pop;
   sym_type    sym_cls;

   // classify the incoming symbol
   always_comb begin
      sym_cls.dplus  = req_bus.dplus;
      sym_cls.dminus = req_bus.dminus;
      sym_cls.se0    = ~req_bus.dplus & ~req_bus.dminus;
   end

   assign req_bus.ready = (count_ff != 2'd2);
   assign push          = req_bus.valid & req_bus.ready;
   assign do_pop        = pop & (count_ff != 2'd0);

   assign head.valid = (count_ff != 2'd0);
   assign head.sym   = mem_ff[rd_ptr_ff];

   // pointer and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= sym_cls;
      end
   end

endmodule

FILE: design/usnd_back.sv
// ----------------------------------------------------------------------------
// usnd_back
// Decoder state machine: sync search, NRZI decode, raw capture, result register.
// ----------------------------------------------------------------------------
module usnd_back
   import usnd_pkg::*;
#(
   parameter int MAX_BITS      = 1024,
   parameter int CAPTURE_LIMIT = 256
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  head_type             head,
   output logic                 pop,
   input  logic [PATTERN_W-1:0] sync_pattern,
   input  logic                 debug_capture,
   usnd_rsp_if.source           rsp_bus
);

   localparam int DW = $clog2(MAX_BITS + 1);
   localparam int CW = $clog2(CAPTURE_LIMIT + 1);
   localparam logic [DW-1:0] MAX_BITS_W      = DW'(MAX_BITS);
   localparam logic [CW-1:0] CAPTURE_LIMIT_W = CW'(CAPTURE_LIMIT);

   phase_type           phase_ff, phase_in;
   logic [PATTERN_W-1:0] window_ff, window_in;
   logic [1:0]          prev_ff, prev_in;
   logic [DW-1:0]       dec_ff, dec_in;
   logic [CW-1:0]       cap_ff, cap_in;
   logic                halted_ff, halted_in;
   logic                load;
   logic [1:0]          sym;
   logic [PATTERN_W-1:0] shifted;

   // result register
   logic               valid_ff;
   logic [1:0]         phase_out_ff;
   logic               bit_valid_ff, bit_valid_in;
   logic               bit_value_ff, bit_value_in;
   logic [INDEX_W-1:0] bit_index_ff, bit_index_in;
   logic               raw_valid_ff, raw_valid_in;
   logic               raw_dplus_ff, raw_dplus_in;
   logic               raw_dminus_ff, raw_dminus_in;
   logic               sync_ff, sync_in;
   logic               eop_ff, eop_in;
   logic               ovf_ff, ovf_in;
   logic               stopped_ff;

   assign load    = head.valid & (~valid_ff | rsp_bus.ready);
   assign pop     = load;
   assign sym     = {head.sym.dminus, head.sym.dplus};
   assign shifted = {sym, window_ff[PATTERN_W-1:2]};

   // next state and result fields
   always_comb begin
      phase_in      = phase_ff;
      window_in     = window_ff;
      prev_in       = prev_ff;
      dec_in        = dec_ff;
      cap_in        = cap_ff;
      halted_in     = halted_ff;
      bit_valid_in  = 1'b0;
      bit_value_in  = 1'b0;
      bit_index_in  = '0;
      raw_valid_in  = 1'b0;
      raw_dplus_in  = 1'b0;
      raw_dminus_in = 1'b0;
      sync_in       = 1'b0;
      eop_in        = 1'b0;
      ovf_in        = 1'b0;
      if (!halted_ff) begin
         unique case (phase_ff)
            PHASE_WAIT: begin
               if (head.sym.dplus) begin
                  window_in = shifted;
                  phase_in  = PHASE_SYNC;
               end
            end
            PHASE_SYNC: begin
               window_in = shifted;
               if (shifted == sync_pattern) begin
                  sync_in  = 1'b1;
                  prev_in  = sym;
                  phase_in = debug_capture ? PHASE_CAPTURE : PHASE_ANALYZE;
               end
            end
            PHASE_ANALYZE: begin
               if (head.sym.se0) begin
                  eop_in    = 1'b1;
                  halted_in = 1'b1;
                  phase_in  = PHASE_WAIT;
               end else begin
                  if (dec_ff < MAX_BITS_W) begin
                     bit_valid_in = 1'b1;
                     bit_value_in = (sym == prev_ff);
                     bit_index_in = INDEX_W'(dec_ff);
                     dec_in       = dec_ff + DW'(1);
                  end else begin
                     ovf_in    = 1'b1;
                     halted_in = 1'b1;
                  end
                  prev_in = sym;
               end
            end
            PHASE_CAPTURE: begin
               raw_valid_in  = 1'b1;
               raw_dplus_in  = head.sym.dplus;
               raw_dminus_in = head.sym.dminus;
               cap_in        = cap_ff + CW'(1);
               if (cap_in >= CAPTURE_LIMIT_W) begin
                  eop_in    = head.sym.se0;
                  halted_in = 1'b1;
                  phase_in  = PHASE_WAIT;
               end
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
      end
   end

   // decoder state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PHASE_WAIT;
         window_ff <= '0;
         prev_ff   <= '0;
         dec_ff    <= '0;
         cap_ff    <= '0;
         halted_ff <= 1'b0;
      end else if (load) begin
         phase_ff  <= phase_in;
         window_ff <= window_in;
         prev_ff   <= prev_in;
         dec_ff    <= dec_in;
         cap_ff    <= cap_in;
         halted_ff <= halted_in;
      end
   end

   // result beat valid
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         valid_ff <= 1'b0;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (load) begin
         phase_out_ff  <= phase_in;
         bit_valid_ff  <= bit_valid_in;
         bit_value_ff  <= bit_value_in;
         bit_index_ff  <= bit_index_in;
         raw_valid_ff  <= raw_valid_in;
         raw_dplus_ff  <= raw_dplus_in;
         raw_dminus_ff <= raw_dminus_in;
         sync_ff       <= sync_in;
         eop_ff        <= eop_in;
         ovf_ff        <= ovf_in;
         stopped_ff    <= halted_in;
      end
   end

   assign rsp_bus.valid         = valid_ff;
   assign rsp_bus.phase         = phase_out_ff;
   assign rsp_bus.bit_valid     = bit_valid_ff;
   assign rsp_bus.bit_value     = bit_value_ff;
   assign rsp_bus.bit_index     = bit_index_ff;
   assign rsp_bus.raw_valid     = raw_valid_ff;
   assign rsp_bus.raw_dplus     = raw_dplus_ff;
   assign rsp_bus.raw_dminus    = raw_dminus_ff;
   assign rsp_bus.sync_detected = sync_ff;
   assign rsp_bus.end_of_packet = eop_ff;
   assign rsp_bus.overflow      = ovf_ff;
   assign rsp_bus.stopped       = stopped_ff;

endmodule

FILE: design/usb_sync_nrzi_line_decoder_unit.sv
// ----------------------------------------------------------------------------
// usb_sync_nrzi_line_decoder_unit
// USB line decoder: sync pattern detect, NRZI decode or raw debug capture.
// ----------------------------------------------------------------------------
// Usage:
//   req_bus carries one sampled D+/D- symbol per beat; rsp_bus returns exactly
//   one result beat per symbol, in order. csr_bus writes register 0 (sync
//   pattern, oldest symbol in the low bits) and register 1 (debug capture);
//   other indexes are ignored. csr_bus is always ready and writes are meant
//   for idle periods only.
//   A symbol beat passes through the front queue storage and then the result
//   register, which the decoder loads. Throughput is one symbol per cycle
//   while the receiver does not stall, as the decoder updates its state for
//   each symbol before the next one.
//   When the receiver stalls, the result register holds its beat and the
//   two-entry front queue absorbs further symbols; req_bus.ready falls once
//   the queue is full.
//   Reset clears the queue, the decoder state and the registers to their
//   reset values. After a stop the block reports stopped on every beat until
//   reset.
// ----------------------------------------------------------------------------
module usb_sync_nrzi_line_decoder_unit
   import usnd_pkg::*;
#(
   parameter int MAX_BITS      = 1024,
   parameter int CAPTURE_LIMIT = 256
)
(
   input  logic       clock,
   input  logic       reset,
   usnd_req_if.sink   req_bus,
   usnd_rsp_if.source rsp_bus,
   usnd_csr_if.sink   csr_bus
);

   logic [PATTERN_W-1:0] sync_pattern_ff;
   logic                 debug_capture_ff;
   head_type             head;
   logic                 pop;

   // register writes
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_pattern_ff  <= SYNC_PATTERN_RESET;
         debug_capture_ff <= 1'b0;
      end else if (csr_bus.valid) begin
         unique case (csr_bus.index)
            CSR_SYNC_PATTERN:  sync_pattern_ff  <= csr_bus.data[PATTERN_W-1:0];
            CSR_DEBUG_CAPTURE: debug_capture_ff <= csr_bus.data[0];
            default: begin
               sync_pattern_ff <= sync_pattern_ff;
            end
         endcase
      end
   end

   // symbol queue
   usnd_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .head    (head),
      .pop     (pop)
   );

   // decoder
   usnd_back #(
      .MAX_BITS      (MAX_BITS),
      .CAPTURE_LIMIT (CAPTURE_LIMIT)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .head          (head),
      .pop           (pop),
      .sync_pattern  (sync_pattern_ff),
      .debug_capture (debug_capture_ff),
      .rsp_bus       (rsp_bus)
   );

endmodule
